>>> rtl/i2d_pkg.sv
// ----------------------------------------------------------------------------
// i2d_pkg
// Shared constants and helpers for the integer to decimal text converter.
// ----------------------------------------------------------------------------
package i2d_pkg;

  localparam int DEF_VALUE_WIDTH = 32;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Decimal digits needed for a w-bit magnitude: floor(w * log10(2)) + 1.
  function automatic int bcd_digits(input int w);
    return (w * 30103) / 100000 + 1;
  endfunction

  // Stream bus width rounded up to whole bytes.
  function automatic int byte_width(input int w);
    return ((w + 7) / 8) * 8;
  endfunction

endpackage

>>> rtl/i2d_conv.sv
// ----------------------------------------------------------------------------
// i2d_conv
// Bit-serial binary to BCD conversion (shift and add-3), one input bit a cycle.
// ----------------------------------------------------------------------------
module i2d_conv import i2d_pkg::*; #(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int NUM_DIGITS  = bcd_digits(DEF_VALUE_WIDTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start_i,
  input  logic [VALUE_WIDTH-1:0]    value_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic                      neg_o,
  output logic [NUM_DIGITS*4-1:0]   bcd_o
);

  localparam int CW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int BW = NUM_DIGITS * 4;

  logic                   busy_r;
  logic                   done_r;
  logic                   neg_r;
  logic [CW-1:0]          cnt_r;
  logic [VALUE_WIDTH-1:0] mag_r;
  logic [BW-1:0]          bcd_r;
  logic [BW-1:0]          bcd_adj;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                       : bcd_r[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start_i && busy_r && (cnt_r == CW'(VALUE_WIDTH - 1));
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(VALUE_WIDTH - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      neg_r <= value_i[VALUE_WIDTH-1];
      mag_r <= value_i[VALUE_WIDTH-1] ? (~value_i + VALUE_WIDTH'(1)) : value_i;
      bcd_r <= '0;
    end else if (busy_r) begin
      mag_r <= {mag_r[VALUE_WIDTH-2:0], 1'b0};
      bcd_r <= {bcd_adj[BW-2:0], mag_r[VALUE_WIDTH-1]};
    end
  end

  assign busy_o = busy_r;
  assign done_o = done_r;
  assign neg_o  = neg_r;
  assign bcd_o  = bcd_r;

endmodule

>>> rtl/i2d_emit.sv
// ----------------------------------------------------------------------------
// i2d_emit
// Walks the BCD digits one nibble a cycle unless stalled or on a sign or comma,
// drops leading zeros and sends sign, digits, group commas via a registered output stage.
// ----------------------------------------------------------------------------
module i2d_emit import i2d_pkg::*; #(
  parameter int NUM_DIGITS = bcd_digits(DEF_VALUE_WIDTH)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load_i,
  input  logic                    neg_i,
  input  logic [NUM_DIGITS*4-1:0] bcd_i,
  output logic                    busy_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [7:0]              out_char_o,
  output logic                    out_last_o
);

  localparam int BW = NUM_DIGITS * 4;
  localparam int RW = $clog2(NUM_DIGITS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SKIP  = 3'd1;
  localparam logic [2:0] S_SIGN  = 3'd2;
  localparam logic [2:0] S_DIGIT = 3'd3;
  localparam logic [2:0] S_COMMA = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;

  logic [2:0]    state_r;
  logic [BW-1:0] bcd_r;
  logic [RW-1:0] rem_r;
  logic [1:0]    grp_r;    // rem_r mod 3
  logic          neg_r;
  logic          valid_r;
  logic [7:0]    char_r;
  logic          last_r;

  logic          can_load;
  logic          load_char;
  logic [3:0]    top_dig;
  logic [1:0]    grp_dec;

  assign can_load  = !valid_r || out_ready_i;
  assign load_char = can_load &&
                     (state_r == S_SIGN || state_r == S_DIGIT || state_r == S_COMMA);
  assign top_dig   = bcd_r[BW-1 -: 4];
  assign grp_dec   = (grp_r == 2'd0) ? 2'd2 : grp_r - 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      valid_r <= load_char || (valid_r && !out_ready_i);
      unique case (state_r)
        S_IDLE: begin
          if (load_i) state_r <= S_SKIP;
        end
        S_SKIP: begin
          if (top_dig == 4'd0 && rem_r > RW'(1)) begin
            state_r <= S_SKIP;
          end else begin
            state_r <= neg_r ? S_SIGN : S_DIGIT;
          end
        end
        S_SIGN: begin
          if (can_load) state_r <= S_DIGIT;
        end
        S_DIGIT: begin
          if (can_load) begin
            if (rem_r == RW'(1)) state_r <= S_DRAIN;
            else if (grp_r == 2'd1) state_r <= S_COMMA;
          end
        end
        S_COMMA: begin
          if (can_load) state_r <= S_DIGIT;
        end
        S_DRAIN: begin
          if (out_ready_i) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (load_i) begin
          bcd_r <= bcd_i;
          neg_r <= neg_i;
          rem_r <= RW'(NUM_DIGITS);
          grp_r <= 2'(NUM_DIGITS % 3);
        end
      end
      S_SKIP: begin
        if (top_dig == 4'd0 && rem_r > RW'(1)) begin
          bcd_r <= {bcd_r[BW-5:0], 4'h0};
          rem_r <= rem_r - RW'(1);
          grp_r <= grp_dec;
        end
      end
      S_SIGN: begin
        if (can_load) begin
          char_r <= CHAR_MINUS;
          last_r <= 1'b0;
        end
      end
      S_DIGIT: begin
        if (can_load) begin
          char_r <= CHAR_ZERO + {4'h0, top_dig};
          last_r <= (rem_r == RW'(1));
          bcd_r  <= {bcd_r[BW-5:0], 4'h0};
          rem_r  <= rem_r - RW'(1);
          grp_r  <= grp_dec;
        end
      end
      S_COMMA: begin
        if (can_load) begin
          char_r <= CHAR_COMMA;
          last_r <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign busy_o      = (state_r != S_IDLE);
  assign out_valid_o = valid_r;
  assign out_char_o  = char_r;
  assign out_last_o  = last_r;

endmodule

>>> rtl/int_to_decimal_with_commas_top.sv
// Flow: bit-serial BCD conversion of the value, then leading zero digits
//   dropped, then one output word per cycle while out_tready is high; the
//   first word follows the conversion, zero skip and output register.
// Throughput: one value at a time, bounded by the add-3 loop and digit walk;
//   the next value is taken only after the last character is accepted.
// Reset: rst_n synchronous, active low; clears control, no words pending.
// ----------------------------------------------------------------------------
// int_to_decimal_with_commas_top
// Signed integer to ASCII decimal text with thousands commas, one char a word.
// ----------------------------------------------------------------------------
module int_to_decimal_with_commas_top import i2d_pkg::*; #(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [byte_width(VALUE_WIDTH)-1:0] in_tdata,  // [VALUE_WIDTH-1:0] value
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,   // [7:0] text_char
  output logic                             out_tlast    // last_char
);

  localparam int NUM_DIGITS = bcd_digits(VALUE_WIDTH);

  logic                    in_accept;
  logic                    conv_busy;
  logic                    conv_done;
  logic                    conv_neg;
  logic [NUM_DIGITS*4-1:0] conv_bcd;
  logic                    emit_busy;

  assign in_tready = !conv_busy && !conv_done && !emit_busy;
  assign in_accept = in_tvalid && in_tready;

  i2d_conv #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NUM_DIGITS)
  ) u_conv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (in_accept),
    .value_i (in_tdata[VALUE_WIDTH-1:0]),
    .busy_o  (conv_busy),
    .done_o  (conv_done),
    .neg_o   (conv_neg),
    .bcd_o   (conv_bcd)
  );

  i2d_emit #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (conv_done),
    .neg_i       (conv_neg),
    .bcd_i       (conv_bcd),
    .busy_o      (emit_busy),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_char_o  (out_tdata),
    .out_last_o  (out_tlast)
  );

endmodule

>>> rtl/i2d_chk.sv
// ----------------------------------------------------------------------------
// i2d_chk
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module i2d_chk import i2d_pkg::*; (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [7:0]                         out_tdata,
  input logic                               out_tlast
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // a new value only starts once the previous text is fully delivered
  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !out_tvalid)
    else $error("value accepted while text pending");

  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after acceptance");

  // text always ends on a digit
  a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata == CHAR_COMMA || out_tdata == CHAR_MINUS) |-> !out_tlast)
    else $error("text ends on comma or minus");

  a_no_out_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("word emitted after last character");

endmodule

bind int_to_decimal_with_commas_top i2d_chk u_i2d_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the integer to decimal text converter. Each accepted value without a
// directed text is run through a local model of the digit grouping and sign
// rules; each output word is compared against the oldest expected character.
// Both stream sides idle at random, with one long output stall and full drains.
// ----------------------------------------------------------------------------
module testbench import i2d_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW          = DEF_VALUE_WIDTH;
  localparam int NUM_RANDOM  = 390;
  localparam int LONG_STALL  = 400;
  localparam int DRAIN_WAIT  = 80;
  localparam int MAX_PRINTS  = 40;
  localparam int NUM_DIR     = 20;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } char_word_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [byte_width(VW)-1:0]   in_tdata = '0;   // [31:0] value
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [7:0]                  out_tdata;       // [7:0] text_char
  logic                        out_tlast;       // last_char

  char_word_t expected_chars[$];
  int         error_count = 0;
  bit         long_hold = 1'b0;

  // Directed values; a nonempty text is the exact expected string,
  // an empty one defers to the digit model.
  logic [VW-1:0] dir_values [NUM_DIR] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h8000_0001, 32'd9, 32'd10, 32'd999, 32'd1000,
    -32'd1000, 32'd999999, 32'd1000000, -32'd999, 32'd1000000000,
    32'hAAAA_AAAA, 32'h5555_5555, 32'd12345, -32'd123456, 32'd100
  };
  string dir_texts [NUM_DIR] = '{
    "0", "1", "-1", "2,147,483,647", "-2,147,483,648",
    "-2,147,483,647", "9", "10", "999", "1,000",
    "-1,000", "999,999", "1,000,000", "-999", "1,000,000,000",
    "", "", "", "", ""
  };

  logic [VW-1:0] pow10 [10] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
    32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
  };

  int_to_decimal_with_commas_top #(.VALUE_WIDTH(VW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Decimal text of one value, most significant character first.
  function automatic void queue_decimal_text(input logic [VW-1:0] value);
    logic [VW-1:0] mag;
    logic [7:0]    rev[$];
    int            digits;
    int            k;
    mag = value[VW-1] ? (~value + 1'b1) : value;
    digits = 0;
    do begin
      rev.push_back(CHAR_ZERO + 8'(mag % 10));
      digits++;
      mag = mag / 10;
      if (digits % 3 == 0 && mag != 0) rev.push_back(CHAR_COMMA);
    end while (mag != 0);
    if (value[VW-1]) rev.push_back(CHAR_MINUS);
    for (k = rev.size() - 1; k >= 0; k--) expected_chars.push_back('{rev[k], k == 0});
  endfunction

  function automatic void queue_literal_text(input string text);
    int i;
    for (i = 0; i < text.len(); i++)
      expected_chars.push_back('{text[i], i == text.len() - 1});
  endfunction

  function automatic logic [VW-1:0] pick_value();
    logic [VW-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom;
      4:          v = $urandom_range(0, 999);
      5:          v = pow10[$urandom_range(0, 9)] + $urandom_range(0, 4) - 2;
      6:          v = $urandom_range(0, 99999);
      7:          v = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                        : 32'h7FFF_FFFF - $urandom_range(0, 3);
      default:    v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  // Called right after a rising edge; returns at the edge that took the word.
  task automatic offer_value(input logic [VW-1:0] value, input string text);
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (text.len() != 0) queue_literal_text(text);
    else queue_decimal_text(value);
  endtask

  always @(posedge clk) begin
    char_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        flag_error($sformatf("unexpected word %h last %b", out_tdata, out_tlast));
      end else begin
        want = expected_chars.pop_front();
        if (out_tdata !== want.text_char)
          flag_error($sformatf("text_char %h, expected %h", out_tdata, want.text_char));
        if (out_tlast !== want.last_char)
          flag_error($sformatf("last_char %b, expected %b on char %h",
                               out_tlast, want.last_char, want.text_char));
      end
    end
  end

  // Receiver: stretches of always-ready, coin-flip, mostly-ready, mostly-stalled.
  initial begin : receiver
    int mode;
    int span;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        long_hold = 1'b0;
      end
      mode = $urandom_range(3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= $urandom_range(1);
          2:       out_tready <= ($urandom_range(7) != 0);
          default: out_tready <= ($urandom_range(7) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : sender
    int  i;
    int  sent;
    int  burst;
    bit  stalled_once;
    bit  drained_once;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < NUM_DIR; i++) begin
      offer_value(dir_values[i], dir_texts[i]);
      if ($urandom_range(2) == 0) begin
        in_tvalid <= 1'b0;
        in_tdata  <= $urandom;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
    wait (expected_chars.size() == 0);
    @(posedge clk);

    sent = 0;
    stalled_once = 1'b0;
    drained_once = 1'b0;
    while (sent < NUM_RANDOM) begin
      burst = ($urandom_range(4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      repeat (burst) begin
        if (sent < NUM_RANDOM) begin
          // long output stall while values keep coming: input must back up
          if (sent == 120 && !stalled_once) begin
            stalled_once = 1'b1;
            long_hold = 1'b1;
          end
          offer_value(pick_value(), "");
          sent++;
        end
      end
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      if (sent >= 250 && !drained_once) begin
        drained_once = 1'b1;
        wait (expected_chars.size() == 0);
        @(posedge clk);
      end
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end

    wait (expected_chars.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_chars.size() != 0)
      flag_error($sformatf("%0d chars never arrived", expected_chars.size()));
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

>>> int_to_decimal_with_commas_top.f
rtl/i2d_pkg.sv
rtl/i2d_conv.sv
rtl/i2d_emit.sv
rtl/int_to_decimal_with_commas_top.sv
rtl/i2d_chk.sv
test/testbench.sv
